/* hw/rtl/md5_pkg.sv */
// Shared types, constants and round helper functions for the MD5 engine.
`default_nettype none
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_POS = 6'h3f;
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  localparam logic [0:0]  OP_APPEND = 1'b0;
  localparam logic [0:0]  OP_FINISH = 1'b1;

  localparam logic [1:0]  ADDR_SAMPLE_MODE = 2'd0;

  // What the compression reads in place of the stored block
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_PAD_LEN,
    BLK_LEN
  } blk_kind_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [3:0]  be;
    logic [31:0] data;
  } buf_wr_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by a round
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
    logic [3:0] g;
    begin
      case (rnd[5:4])
        2'd0: g = rnd[3:0];
        2'd1: g = 4'(5 * rnd[3:0] + 1);
        2'd2: g = 4'(3 * rnd[3:0] + 5);
        default: g = 4'(7 * rnd[3:0]);
      endcase
      return g;
    end
  endfunction

  // Block word as seen by the compression: stored bytes below the fill
  // position, then pad byte, zeros and the length field as the kind asks
  function automatic logic [31:0] md5_word(input logic [31:0] mem,
                                           input logic [3:0] g,
                                           input logic [5:0] pos,
                                           input blk_kind_t kind,
                                           input logic [63:0] cnt);
    logic [31:0] w;
    logic [5:0]  idx;
    begin
      w = mem;
      for (int k = 0; k < 4; k++) begin
        idx = {g, 2'(k)};
        if (kind == BLK_LEN) begin
          w[8*k +: 8] = 8'h00;
        end else if (kind != BLK_DATA) begin
          if (idx == pos) begin
            w[8*k +: 8] = PAD_BYTE;
          end else if (idx > pos) begin
            w[8*k +: 8] = 8'h00;
          end
        end
      end
      if (kind == BLK_PAD_LEN || kind == BLK_LEN) begin
        if (g == 4'd14) begin
          w = cnt[31:0];
        end else if (g == 4'd15) begin
          w = cnt[63:32];
        end
      end
      return w;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/md5_block_buf.sv */
// Block buffer: 16 x 32-bit words, byte-write, registered read.
`default_nettype none
module md5_block_buf
  import md5_pkg::*;
(
  input  wire logic        clk,
  input  wire buf_wr_t     wr,
  input  wire logic [3:0]  raddr,
  output logic      [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int k = 0; k < 4; k++) begin
        if (wr.be[k]) begin
          mem[wr.addr][8*k +: 8] <= wr.data[8*k +: 8];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/md5_round.sv */
// One MD5 round step: boolean function, constant add, rotate, add.
`default_nettype none
module md5_round
  import md5_pkg::*;
(
  input  wire logic [5:0]  rnd,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] word,
  output logic      [31:0] b_new
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s = ROT_AMT[{rnd[5:4], rnd[1:0]}];
    sum = a + f + ROUND_K[rnd] + word;
    rot_wide = {sum, sum} << s;
    b_new = b + rot_wide[63:32];
  end

endmodule
`default_nettype wire

/* hw/rtl/md5_message_digest.sv */
// MD5 digest engine top level: sequencer, chaining state, config and output.
//
// channel | dir | beat contents              | handshake
// in      | in  | op, sample                 | in_valid / in_ready
// out     | out | digest_low, digest_high    | out_valid / out_ready
// cfg     | in  | sample_mode at 0x0         | APB psel/penable/pwrite
//
// Append: accept step, then one byte-write step per byte (one or two bytes
// per item); a byte that fills the block adds operand fetch, 64 rounds through
// one round unit and fold.
// Finish: operand fetch, rounds and fold (two blocks when the fill position is 56
// or more), then the output load; in_ready is high only when the sequencer is idle.
// An unread digest stalls only the next finish; appends keep flowing.
// rst is synchronous and clears the sequencer, chain, count and mode.
`default_nettype none
module md5_message_digest
  import md5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] digest_low,
  output logic      [63:0] digest_high,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_PRE,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  state_t      state;
  blk_kind_t   kind;
  logic        sample_mode;
  logic        two_bytes;
  logic        byte_sel;
  logic [15:0] sample_q;
  logic [63:0] bit_count;
  logic [5:0]  rnd;
  logic [3:0]  g_q;
  logic [31:0] h0, h1, h2, h3;
  logic [31:0] a, b, c, d;

  logic [5:0]  pos;
  logic [7:0]  cur_byte;
  buf_wr_t     wr;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic [31:0] word;
  logic [31:0] b_new;
  logic        cfg_wr;

  assign pos      = bit_count[8:3];
  assign cur_byte = byte_sel ? sample_q[15:8] : sample_q[7:0];
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_SAMPLE_MODE);
  assign prdata   = (paddr == ADDR_SAMPLE_MODE) ? {31'd0, sample_mode} : 32'd0;

  always_comb begin
    wr.en   = (state == S_BYTE);
    wr.addr = pos[5:2];
    wr.be   = 4'(1) << pos[1:0];
    wr.data = {4{cur_byte}};
    raddr   = (state == S_ROUND) ? md5_msg_idx(6'(rnd + 6'd1)) : md5_msg_idx(6'd0);
    word    = md5_word(rdata, g_q, pos, kind, bit_count);
  end

  md5_block_buf u_buf (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  md5_round u_round (
    .rnd   (rnd),
    .a     (a),
    .b     (b),
    .c     (c),
    .d     (d),
    .word  (word),
    .b_new (b_new)
  );

  always_ff @(posedge clk) begin
    g_q <= raddr;
    if (rst) begin
      state       <= S_IDLE;
      kind        <= BLK_DATA;
      sample_mode <= 1'b0;
      two_bytes   <= 1'b0;
      byte_sel    <= 1'b0;
      bit_count   <= 64'd0;
      rnd         <= 6'd0;
      h0          <= INIT_A;
      h1          <= INIT_B;
      h2          <= INIT_C;
      h3          <= INIT_D;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        sample_mode <= pwdata[0];
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_q  <= sample;
            two_bytes <= sample_mode;
            byte_sel  <= 1'b0;
            if (op == OP_FINISH) begin
              kind  <= (pos >= LEN_POS) ? BLK_PAD : BLK_PAD_LEN;
              state <= S_PRE;
            end else begin
              state <= S_BYTE;
            end
          end
        end
        S_BYTE: begin
          bit_count <= bit_count + 64'd8;
          if (pos == LAST_POS) begin
            kind  <= BLK_DATA;
            state <= S_PRE;
          end else if (!byte_sel && two_bytes) begin
            byte_sel <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PRE: begin
          a     <= h0;
          b     <= h1;
          c     <= h2;
          d     <= h3;
          rnd   <= 6'd0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          a   <= d;
          b   <= b_new;
          c   <= b;
          d   <= c;
          rnd <= 6'(rnd + 6'd1);
          if (rnd == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          h0 <= h0 + a;
          h1 <= h1 + b;
          h2 <= h2 + c;
          h3 <= h3 + d;
          case (kind)
            BLK_DATA: begin
              if (!byte_sel && two_bytes) begin
                byte_sel <= 1'b1;
                state    <= S_BYTE;
              end else begin
                state <= S_IDLE;
              end
            end
            BLK_PAD: begin
              kind  <= BLK_LEN;
              state <= S_PRE;
            end
            default: state <= S_OUT;
          endcase
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            digest_low  <= {h1, h0};
            digest_high <= {h3, h2};
            out_valid   <= 1'b1;
            h0          <= INIT_A;
            h1          <= INIT_B;
            h2          <= INIT_C;
            h3          <= INIT_D;
            bit_count   <= 64'd0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fold_after_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(state) == S_ROUND && $past(rnd) == LAST_ROUND))
    else $error("fold entered without completing 64 rounds");

  a_count_byte_aligned: assert property (@(posedge clk) disable iff (rst)
    bit_count[2:0] == 3'd0)
    else $error("bit count not byte aligned");

  a_finish_starts_compress: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_FINISH) |=> (state == S_PRE))
    else $error("finish did not start a compression");

  a_digest_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("digest raised outside output load");

endmodule
`default_nettype wire
